>>> rtl/core/multi_alarm_compare_timer_unit_defines.svh
// assertion macros for the alarm table timer
// used by multi_alarm_compare_timer_unit; no other dependencies
`ifndef MULTI_ALARM_COMPARE_TIMER_UNIT_DEFINES_SVH
`define MULTI_ALARM_COMPARE_TIMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MATU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MATU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MATU_ASSERT(label, clk, rst, prop, msg)
`define MATU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> rtl/core/matu_pkg.sv
// shared types and constants of the alarm table timer
// no dependencies
`timescale 1ns / 1ps

package matu_pkg;

   localparam int TIME_W        = 32;
   localparam int ENTRY_W       = 2 * TIME_W;
   localparam int MAX_REPORTS   = 8;
   localparam int REPORT_CNT_W  = 4;

   localparam logic [2:0] OP_TICK        = 3'd0;
   localparam logic [2:0] OP_SET_REL     = 3'd1;
   localparam logic [2:0] OP_SET_ABS     = 3'd2;
   localparam logic [2:0] OP_CANCEL      = 3'd3;
   localparam logic [2:0] OP_QUERY       = 3'd4;
   localparam logic [2:0] OP_SET_HANDLER = 3'd5;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_BAD_ID = 2'd1;
   localparam logic [1:0] STATUS_RANGE  = 2'd2;

   localparam logic [1:0] TICK_COUNTER = 2'd0;

   localparam logic CSR_COUNTER_MAX   = 1'b0;
   localparam logic CSR_MIN_INCREMENT = 1'b1;

   localparam logic [TIME_W-1:0] COUNTER_MAX_RESET   = 32'd65535;
   localparam logic [TIME_W-1:0] MIN_INCREMENT_RESET = 32'd1;

   typedef struct packed {
      logic [2:0]        operation;
      logic [7:0]        alarm_id;
      logic [1:0]        counter_id;
      logic [TIME_W-1:0] counter_value;
      logic [TIME_W-1:0] amount;
      logic [TIME_W-1:0] cycle;
      logic              handler_flag;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              fired;
      logic [7:0]        fired_alarm;
      logic              is_armed;
      logic [TIME_W-1:0] alarm_time;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              go;
      logic [TIME_W-1:0] base;
      logic [TIME_W-1:0] inc;
      logic [TIME_W-1:0] counter_max;
   } wrap_cmd_type;

   typedef struct packed {
      logic              done;
      logic              busy;
      logic [TIME_W-1:0] result;
   } wrap_sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMD,
      ST_CMD_WRAP,
      ST_QUERY,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SCAN_WRAP,
      ST_SCAN_END
   } state_type;

endpackage

>>> rtl/core/matu_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module matu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/matu_wrap_unit.sv
// bit-serial (base + inc) mod (counter_max + 1), one remainder bit per cycle
// depends on matu_pkg
`timescale 1ns / 1ps

module matu_wrap_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  matu_pkg::wrap_cmd_type cmd,
   output matu_pkg::wrap_sts_type sts
);

   localparam int SUM_W = matu_pkg::TIME_W + 1;
   localparam int CNT_W = $clog2(SUM_W + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SUM_W - 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] mod_ff;
   logic [SUM_W-1:0] rem_ff;
   logic [SUM_W-1:0] rem_in;
   logic [SUM_W:0]   trial;
   logic [SUM_W:0]   mod_ext;

   always_comb begin
      trial   = {rem_ff, sum_ff[SUM_W-1]};
      mod_ext = {1'b0, mod_ff};
      if (trial >= mod_ext) begin
         rem_in = SUM_W'(trial - mod_ext);
      end else begin
         rem_in = trial[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.go) begin
         sum_ff <= SUM_W'(cmd.base) + SUM_W'(cmd.inc);
         mod_ff <= SUM_W'(cmd.counter_max) + SUM_W'(1);
         rem_ff <= '0;
      end else if (busy_ff) begin
         sum_ff <= {sum_ff[SUM_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign sts.done   = done_ff;
   assign sts.busy   = busy_ff;
   assign sts.result = rem_ff[matu_pkg::TIME_W-1:0];

endmodule

>>> rtl/core/multi_alarm_compare_timer_unit.sv
// alarm table timer top level: sequencer, alarm flags, entry ram, wrap unit
// depends on matu_pkg, matu_ram, matu_wrap_unit and the assertion macro header
//
// usage: a transaction is taken when start is high and busy is low; req_data
// carries the operation. results leave on rsp_data, marked by rsp_valid for
// exactly one cycle; the receiver cannot stall them. csr_we writes counter_max
// (index 0) or min_increment (index 1) from csr_wdata; it must be used only
// while busy is low, as the block does not enforce it. non-tick operations give
// one result, query after reading the entry ram and set relative once its wrap
// has run through the shared bit-serial modulo unit (33 steps). a tick on
// counter 0 visits every alarm slot in turn, reads and checks each armed one,
// waits on the wrap unit for each cyclic alarm that fires and re-arms, and
// closes in an end state. each firing alarm with a handler gives one result
// (at most 8), the final one flagged last; a tick with no such alarm gives no
// result. reset is synchronous: all alarms disarmed, no handlers, times read as
// zero, counter_max 65535, min_increment 1. there is no clearing pass.
`timescale 1ns / 1ps
`include "multi_alarm_compare_timer_unit_defines.svh"

module multi_alarm_compare_timer_unit #(
   parameter int ALARM_COUNT = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  matu_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output matu_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [matu_pkg::TIME_W-1:0]       csr_wdata
);

   localparam int IDX_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALARM_COUNT - 1);
   localparam logic [8:0] ID_LIMIT = 9'(ALARM_COUNT);
   localparam int TW = matu_pkg::TIME_W;
   localparam int RW = matu_pkg::REPORT_CNT_W;

   matu_pkg::state_type state_ff, state_in;
   matu_pkg::req_type   req_ff;
   matu_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff;

   logic [ALARM_COUNT-1:0] armed_ff;
   logic [ALARM_COUNT-1:0] handler_ff;
   logic [ALARM_COUNT-1:0] tvalid_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic                   pend_valid_ff;
   logic [IDX_W-1:0]       pend_id_ff;
   logic [RW-1:0]          rep_cnt_ff;
   logic [TW-1:0]          cmax_ff;
   logic [TW-1:0]          minc_ff;

   logic                         ram_we, ram_re;
   logic [IDX_W-1:0]             ram_waddr, ram_raddr;
   logic [matu_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
   matu_pkg::wrap_cmd_type       wrap_cmd;
   matu_pkg::wrap_sts_type       wrap_sts;

   logic             emit, arm_we, arm_val, hdl_we, tv_set;
   logic             idx_adv, scan_init, pend_take, pend_clear;
   logic [IDX_W-1:0] cmd_idx, arm_idx;
   logic             id_ok, rel_bad, abs_bad, is_last, fire;
   logic [TW-1:0]    rd_expiry, rd_period;

   matu_ram #(
      .WIDTH (matu_pkg::ENTRY_W),
      .DEPTH (ALARM_COUNT)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   matu_wrap_unit u_wrap (
      .clock (clock),
      .reset (reset),
      .cmd   (wrap_cmd),
      .sts   (wrap_sts)
   );

   assign busy      = (state_ff != matu_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign cmd_idx   = req_ff.alarm_id[IDX_W-1:0];
   assign id_ok     = ({1'b0, req_ff.alarm_id} < ID_LIMIT);
   assign rel_bad   = (req_ff.amount < minc_ff) || (req_ff.amount > cmax_ff)
                      || (req_ff.cycle > cmax_ff);
   assign abs_bad   = (req_ff.amount > cmax_ff) || (req_ff.cycle > cmax_ff);
   assign is_last   = (idx_ff == LAST_IDX);
   assign rd_expiry = ram_rdata[TW-1:0];
   assign rd_period = ram_rdata[matu_pkg::ENTRY_W-1:TW];
   assign fire      = armed_ff[idx_ff] && (rd_expiry == req_ff.counter_value);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         matu_pkg::ST_IDLE: begin
            if (start) begin
               state_in = matu_pkg::ST_CMD;
            end
         end
         matu_pkg::ST_CMD: begin
            state_in = matu_pkg::ST_IDLE;
            case (req_ff.operation)
               matu_pkg::OP_TICK: begin
                  if (req_ff.counter_id == matu_pkg::TICK_COUNTER) begin
                     state_in = matu_pkg::ST_SCAN_RD;
                  end
               end
               matu_pkg::OP_SET_REL: begin
                  if (id_ok && !rel_bad) begin
                     state_in = matu_pkg::ST_CMD_WRAP;
                  end
               end
               matu_pkg::OP_QUERY: begin
                  if (id_ok) begin
                     state_in = matu_pkg::ST_QUERY;
                  end
               end
               default: state_in = matu_pkg::ST_IDLE;
            endcase
         end
         matu_pkg::ST_CMD_WRAP: begin
            if (wrap_sts.done) begin
               state_in = matu_pkg::ST_IDLE;
            end
         end
         matu_pkg::ST_QUERY: state_in = matu_pkg::ST_IDLE;
         matu_pkg::ST_SCAN_RD: begin
            if (armed_ff[idx_ff]) begin
               state_in = matu_pkg::ST_SCAN_CHK;
            end else if (is_last) begin
               state_in = matu_pkg::ST_SCAN_END;
            end
         end
         matu_pkg::ST_SCAN_CHK: begin
            if (fire && (rd_period != '0)) begin
               state_in = matu_pkg::ST_SCAN_WRAP;
            end else if (is_last) begin
               state_in = matu_pkg::ST_SCAN_END;
            end else begin
               state_in = matu_pkg::ST_SCAN_RD;
            end
         end
         matu_pkg::ST_SCAN_WRAP: begin
            if (wrap_sts.done) begin
               state_in = is_last ? matu_pkg::ST_SCAN_END : matu_pkg::ST_SCAN_RD;
            end
         end
         matu_pkg::ST_SCAN_END: state_in = matu_pkg::ST_IDLE;
         default: state_in = matu_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      emit       = 1'b0;
      rsp_in     = '0;
      ram_we     = 1'b0;
      ram_waddr  = cmd_idx;
      ram_wdata  = {req_ff.cycle, req_ff.amount};
      ram_re     = 1'b0;
      ram_raddr  = cmd_idx;
      arm_we     = 1'b0;
      arm_val    = 1'b0;
      arm_idx    = cmd_idx;
      hdl_we     = 1'b0;
      tv_set     = 1'b0;
      idx_adv    = 1'b0;
      scan_init  = 1'b0;
      pend_take  = 1'b0;
      pend_clear = 1'b0;
      wrap_cmd.go          = 1'b0;
      wrap_cmd.base        = req_ff.counter_value;
      wrap_cmd.inc         = req_ff.amount;
      wrap_cmd.counter_max = cmax_ff;
      unique case (state_ff)
         matu_pkg::ST_IDLE: begin
         end
         matu_pkg::ST_CMD: begin
            rsp_in.last = 1'b1;
            case (req_ff.operation) inside
               matu_pkg::OP_TICK: begin
                  rsp_in.last = 1'b0;
                  scan_init   = (req_ff.counter_id == matu_pkg::TICK_COUNTER);
               end
               matu_pkg::OP_SET_REL, matu_pkg::OP_SET_ABS, matu_pkg::OP_CANCEL,
               matu_pkg::OP_QUERY, matu_pkg::OP_SET_HANDLER: begin
                  if (!id_ok) begin
                     emit          = 1'b1;
                     rsp_in.status = matu_pkg::STATUS_BAD_ID;
                  end else begin
                     case (req_ff.operation)
                        matu_pkg::OP_SET_REL: begin
                           if (rel_bad) begin
                              emit          = 1'b1;
                              rsp_in.status = matu_pkg::STATUS_RANGE;
                           end else begin
                              wrap_cmd.go = 1'b1;
                           end
                        end
                        matu_pkg::OP_SET_ABS: begin
                           emit = 1'b1;
                           if (abs_bad) begin
                              rsp_in.status = matu_pkg::STATUS_RANGE;
                           end else begin
                              ram_we  = 1'b1;
                              arm_we  = 1'b1;
                              arm_val = 1'b1;
                              tv_set  = 1'b1;
                           end
                        end
                        matu_pkg::OP_CANCEL: begin
                           emit   = 1'b1;
                           arm_we = 1'b1;
                        end
                        matu_pkg::OP_QUERY: begin
                           ram_re = 1'b1;
                        end
                        default: begin
                           emit   = 1'b1;
                           hdl_we = 1'b1;
                        end
                     endcase
                  end
               end
               default: emit = 1'b1;
            endcase
         end
         matu_pkg::ST_CMD_WRAP: begin
            if (wrap_sts.done) begin
               emit        = 1'b1;
               rsp_in.last = 1'b1;
               ram_we      = 1'b1;
               ram_wdata   = {req_ff.cycle, wrap_sts.result};
               arm_we      = 1'b1;
               arm_val     = 1'b1;
               tv_set      = 1'b1;
            end
         end
         matu_pkg::ST_QUERY: begin
            emit              = 1'b1;
            rsp_in.last       = 1'b1;
            rsp_in.is_armed   = armed_ff[cmd_idx];
            rsp_in.alarm_time = tvalid_ff[cmd_idx] ? rd_expiry : '0;
         end
         matu_pkg::ST_SCAN_RD: begin
            ram_raddr = idx_ff;
            if (armed_ff[idx_ff]) begin
               ram_re = 1'b1;
            end else begin
               idx_adv = !is_last;
            end
         end
         matu_pkg::ST_SCAN_CHK: begin
            arm_idx       = idx_ff;
            wrap_cmd.base = req_ff.counter_value;
            wrap_cmd.inc  = rd_period;
            if (fire) begin
               if (handler_ff[idx_ff] && (rep_cnt_ff < RW'(matu_pkg::MAX_REPORTS))) begin
                  pend_take          = 1'b1;
                  emit               = pend_valid_ff;
                  rsp_in.fired       = 1'b1;
                  rsp_in.fired_alarm = 8'(pend_id_ff);
               end
               if (rd_period != '0) begin
                  wrap_cmd.go = 1'b1;
               end else begin
                  arm_we = 1'b1;
               end
            end
            idx_adv = !(fire && (rd_period != '0)) && !is_last;
         end
         matu_pkg::ST_SCAN_WRAP: begin
            ram_waddr = idx_ff;
            ram_wdata = {rd_period, wrap_sts.result};
            if (wrap_sts.done) begin
               ram_we  = 1'b1;
               idx_adv = !is_last;
            end
         end
         matu_pkg::ST_SCAN_END: begin
            emit               = pend_valid_ff;
            pend_clear         = 1'b1;
            rsp_in.fired       = 1'b1;
            rsp_in.fired_alarm = 8'(pend_id_ff);
            rsp_in.last        = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= matu_pkg::ST_IDLE;
         armed_ff      <= '0;
         handler_ff    <= '0;
         tvalid_ff     <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rep_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         cmax_ff       <= matu_pkg::COUNTER_MAX_RESET;
         minc_ff       <= matu_pkg::MIN_INCREMENT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit;
         if (arm_we) begin
            armed_ff[arm_idx] <= arm_val;
         end
         if (hdl_we) begin
            handler_ff[cmd_idx] <= req_ff.handler_flag;
         end
         if (tv_set) begin
            tvalid_ff[cmd_idx] <= 1'b1;
         end
         if (scan_init) begin
            idx_ff        <= '0;
            pend_valid_ff <= 1'b0;
            rep_cnt_ff    <= '0;
         end else begin
            if (idx_adv) begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
            if (pend_take) begin
               pend_valid_ff <= 1'b1;
               rep_cnt_ff    <= rep_cnt_ff + RW'(1);
            end else if (pend_clear) begin
               pend_valid_ff <= 1'b0;
            end
         end
         if (csr_we) begin
            unique case (csr_index)
               matu_pkg::CSR_COUNTER_MAX:   cmax_ff <= csr_wdata;
               matu_pkg::CSR_MIN_INCREMENT: minc_ff <= csr_wdata;
               default: cmax_ff <= cmax_ff;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      if (pend_take) begin
         pend_id_ff <= idx_ff;
      end
      rsp_ff <= rsp_in;
   end

   `MATU_ASSERT(a_not_last_is_firing, clock, reset,
      (rsp_valid && !rsp_data.last) |-> rsp_data.fired, "non-final result is not a firing")
   `MATU_ASSERT(a_wrap_not_restarted, clock, reset,
      wrap_cmd.go |-> !wrap_sts.busy, "wrap unit started while busy")
   `MATU_ASSERT(a_idle_no_pending, clock, reset,
      (state_ff == matu_pkg::ST_IDLE) |-> !pend_valid_ff, "pending firing left behind")
   `MATU_ASSERT(a_report_limit, clock, reset,
      rep_cnt_ff <= RW'(matu_pkg::MAX_REPORTS), "too many firings reported")

endmodule
